/* rtl/core/kmst_pkg.sv */
// Shared types and constants for the spanning tree engine.
`timescale 1ns / 1ps
package kmst_pkg;
    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_EDGES    = 256;
    localparam int W_WIDTH    = 16;
    localparam int ID_WIDTH   = 6;
    localparam int CNT_WIDTH  = 7;
    localparam int COST_WIDTH = 22;
    localparam int KEY_WIDTH  = W_WIDTH + 2 * ID_WIDTH;
    localparam logic [CNT_WIDTH-1:0] VCOUNT_RESET = 7'd64;

    // Front-to-back queue word: an edge key with a last-edge flag and a drop flag.
    typedef struct packed {
        logic                 fin;
        logic                 drop;
        logic [KEY_WIDTH-1:0] key;
    } cmd_t;
endpackage

/* rtl/core/kmst_front.sv */
// Front end: accepts edges, checks endpoint range and capacity, queues commands.
`timescale 1ns / 1ps
module kmst_front #(
    parameter int MAX_VERTICES = kmst_pkg::DEF_MAX_VERTICES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic signed [kmst_pkg::W_WIDTH-1:0]  edge_weight,
    input  logic [kmst_pkg::ID_WIDTH-1:0]   end_u,
    input  logic [kmst_pkg::ID_WIDTH-1:0]   end_v,
    input  logic                            last_edge,
    input  logic [kmst_pkg::CNT_WIDTH-1:0]  vcount,
    output logic                            q_valid,
    output kmst_pkg::cmd_t                  q_data,
    input  logic                            q_pop
);
    import kmst_pkg::*;
    localparam int QD = 4;
    localparam int QA = $clog2(QD);
    localparam logic [CNT_WIDTH-1:0] MAXV = CNT_WIDTH'(MAX_VERTICES);

    cmd_t             mem [QD];
    logic [QA:0]      wp_reg, rp_reg, wp_next, rp_next;
    logic [CNT_WIDTH-1:0] lim;
    logic             bad;
    cmd_t             cmd;
    logic             wr;

    assign lim = (vcount > MAXV) ? MAXV : vcount;
    assign bad = ({1'b0, end_u} >= lim) || ({1'b0, end_v} >= lim);
    assign full = (wp_reg[QA] != rp_reg[QA]) && (wp_reg[QA-1:0] == rp_reg[QA-1:0]);
    assign q_valid = wp_reg != rp_reg;
    assign q_data = mem[rp_reg[QA-1:0]];
    assign wr = push && !full;
    assign wp_next = wp_reg + (QA+1)'(wr);
    assign rp_next = rp_reg + (QA+1)'(q_pop && q_valid);

    always_comb
    begin
        cmd.fin  = last_edge;
        cmd.drop = bad;
        cmd.key  = {~edge_weight[W_WIDTH-1], edge_weight[W_WIDTH-2:0], end_u, end_v};
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wp_reg[QA-1:0]] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
        end
    end

    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (wp_reg - rp_reg) <= (QA+1)'(QD)) else $error("queue overfill");
    a_no_wr_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |=> wp_reg == $past(wp_reg)) else $error("write while full");
    a_no_rd_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !q_valid |=> rp_reg == $past(rp_reg)) else $error("read while empty");
endmodule

/* rtl/core/kmst_back.sv */
// Back end: stores edges, sorts them, runs union-find and emits tree edges.
`timescale 1ns / 1ps
module kmst_back #(
    parameter int MAX_VERTICES = kmst_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = kmst_pkg::DEF_MAX_EDGES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  kmst_pkg::cmd_t                  q_data,
    output logic                            q_pop,
    output logic                            empty,
    input  logic                            pop,
    output logic                            edge_valid,
    output logic [kmst_pkg::ID_WIDTH-1:0]   tree_u,
    output logic [kmst_pkg::ID_WIDTH-1:0]   tree_v,
    output logic signed [kmst_pkg::W_WIDTH-1:0]   chosen_weight,
    output logic signed [kmst_pkg::COST_WIDTH-1:0] running_cost,
    output logic                            dropped_flag,
    output logic                            last_result
);
    import kmst_pkg::*;
    localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int VA = $clog2(MAX_VERTICES);
    localparam logic [EA:0] EMAX  = (EA+1)'(MAX_EDGES);
    localparam logic [VA:0] VLAST = (VA+1)'(MAX_VERTICES - 1);

    typedef enum logic [3:0] {
        S_INIT, S_LOAD, S_SI, S_SK, S_SC, S_SW, S_PI, S_PK,
        S_FRD, S_FCHK, S_JOIN, S_EMIT, S_FIN
    } state_t;

    logic [KEY_WIDTH-1:0] estore [MAX_EDGES];
    logic [VA-1:0]        parent [MAX_VERTICES];

    state_t                st_reg;
    logic [EA:0]           fill_reg, i_reg, j_reg;
    logic [KEY_WIDTH-1:0]  key_reg, rd_reg, cur_reg, pend_key_reg;
    logic [VA:0]           ini_reg;
    logic                  drop_reg, pend_reg, side_reg, ov_reg;
    logic [COST_WIDTH-1:0] cost_reg, pend_cost_reg;
    logic [VA-1:0]         x_reg, ru_reg, rv_reg, prd_reg;

    logic [EA:0]           jm1, jm2;
    logic [ID_WIDTH-1:0]   cv, pu, pv;
    logic [W_WIDTH-1:0]    cw, pw;
    logic [COST_WIDTH-1:0] cost_next;

    logic                  e_we;
    logic [EA-1:0]         e_wa, e_ra;
    logic [KEY_WIDTH-1:0]  e_wd;
    logic                  p_we;
    logic [VA-1:0]         p_wa, p_wd;

    assign jm1 = j_reg - (EA+1)'(1);
    assign jm2 = j_reg - (EA+1)'(2);
    assign cv = cur_reg[ID_WIDTH-1:0];
    assign cw = {~cur_reg[KEY_WIDTH-1], cur_reg[KEY_WIDTH-2:2*ID_WIDTH]};
    assign pu = pend_key_reg[2*ID_WIDTH-1:ID_WIDTH];
    assign pv = pend_key_reg[ID_WIDTH-1:0];
    assign pw = {~pend_key_reg[KEY_WIDTH-1], pend_key_reg[KEY_WIDTH-2:2*ID_WIDTH]};
    assign cost_next = cost_reg + {{(COST_WIDTH-W_WIDTH){cw[W_WIDTH-1]}}, cw};

    assign q_pop = (st_reg == S_LOAD) && q_valid;
    assign empty = !ov_reg;

    // edge memory: one write port, one registered read port
    always_comb
    begin
        e_we = 1'b0;
        e_wa = fill_reg[EA-1:0];
        e_wd = q_data.key;
        e_ra = i_reg[EA-1:0];
        case (st_reg)
            S_LOAD:
            begin
                e_we = q_valid && !q_data.drop && (fill_reg < EMAX);
            end
            S_SK:
            begin
                e_ra = jm1[EA-1:0];
            end
            S_SC:
            begin
                // shift the larger entry up and fetch the one below it
                if (rd_reg > key_reg)
                begin
                    e_we = 1'b1;
                    e_wa = j_reg[EA-1:0];
                    e_wd = rd_reg;
                    e_ra = jm2[EA-1:0];
                end
            end
            S_SW:
            begin
                e_we = 1'b1;
                e_wa = j_reg[EA-1:0];
                e_wd = key_reg;
            end
            default:
            begin
                e_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            estore[e_wa] <= e_wd;
        end
        rd_reg <= estore[e_ra];
    end

    // set store: clearing pass writes each entry to itself, a join links one root
    assign p_we = (st_reg == S_INIT) || ((st_reg == S_JOIN) && (ru_reg != rv_reg));
    assign p_wa = (st_reg == S_INIT) ? ini_reg[VA-1:0] : ru_reg;
    assign p_wd = (st_reg == S_INIT) ? ini_reg[VA-1:0] : rv_reg;

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            parent[p_wa] <= p_wd;
        end
        prd_reg <= parent[x_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_INIT;
            fill_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            ini_reg <= '0;
            drop_reg <= 1'b0;
            pend_reg <= 1'b0;
            side_reg <= 1'b0;
            ov_reg <= 1'b0;
            cost_reg <= '0;
            pend_cost_reg <= '0;
            x_reg <= '0;
            ru_reg <= '0;
            rv_reg <= '0;
            key_reg <= '0;
            cur_reg <= '0;
            pend_key_reg <= '0;
            edge_valid <= 1'b0;
            tree_u <= '0;
            tree_v <= '0;
            chosen_weight <= '0;
            running_cost <= '0;
            dropped_flag <= 1'b0;
            last_result <= 1'b0;
        end
        else
        begin
            if (ov_reg && pop)
            begin
                ov_reg <= 1'b0;
            end
            case (st_reg)
                S_INIT:
                begin
                    if (ini_reg == VLAST)
                    begin
                        ini_reg <= '0;
                        fill_reg <= '0;
                        drop_reg <= 1'b0;
                        cost_reg <= '0;
                        pend_reg <= 1'b0;
                        st_reg <= S_LOAD;
                    end
                    else
                    begin
                        ini_reg <= ini_reg + 1'b1;
                    end
                end
                S_LOAD:
                begin
                    if (q_valid)
                    begin
                        if (q_data.drop || fill_reg >= EMAX)
                        begin
                            drop_reg <= 1'b1;
                        end
                        else
                        begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                        if (q_data.fin)
                        begin
                            i_reg <= (EA+1)'(1);
                            st_reg <= S_SI;
                        end
                    end
                end
                S_SI:
                begin
                    j_reg <= i_reg;
                    if (i_reg >= fill_reg)
                    begin
                        i_reg <= '0;
                        st_reg <= S_PI;
                    end
                    else
                    begin
                        st_reg <= S_SK;
                    end
                end
                S_SK:
                begin
                    key_reg <= rd_reg;
                    st_reg <= S_SC;
                end
                S_SC:
                begin
                    if (rd_reg > key_reg)
                    begin
                        j_reg <= jm1;
                        if (jm1 == '0)
                        begin
                            st_reg <= S_SW;
                        end
                    end
                    else
                    begin
                        st_reg <= S_SW;
                    end
                end
                S_SW:
                begin
                    i_reg <= i_reg + 1'b1;
                    st_reg <= S_SI;
                end
                S_PI:
                begin
                    if (i_reg >= fill_reg)
                    begin
                        st_reg <= S_FIN;
                    end
                    else
                    begin
                        st_reg <= S_PK;
                    end
                end
                S_PK:
                begin
                    cur_reg <= rd_reg;
                    x_reg <= rd_reg[ID_WIDTH+VA-1:ID_WIDTH];
                    side_reg <= 1'b0;
                    st_reg <= S_FRD;
                end
                S_FRD:
                begin
                    st_reg <= S_FCHK;
                end
                S_FCHK:
                begin
                    // climb until an entry points at itself
                    if (prd_reg != x_reg)
                    begin
                        x_reg <= prd_reg;
                        st_reg <= S_FRD;
                    end
                    else if (!side_reg)
                    begin
                        ru_reg <= x_reg;
                        x_reg <= cv[VA-1:0];
                        side_reg <= 1'b1;
                        st_reg <= S_FRD;
                    end
                    else
                    begin
                        rv_reg <= x_reg;
                        st_reg <= S_JOIN;
                    end
                end
                S_JOIN:
                begin
                    if (ru_reg == rv_reg)
                    begin
                        i_reg <= i_reg + 1'b1;
                        st_reg <= S_PI;
                    end
                    else
                    begin
                        cost_reg <= cost_next;
                        st_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    // hold the new edge; release the previous one, which is not last
                    if (!pend_reg || !ov_reg)
                    begin
                        if (pend_reg)
                        begin
                            edge_valid <= 1'b1;
                            tree_u <= pu;
                            tree_v <= pv;
                            chosen_weight <= pw;
                            running_cost <= pend_cost_reg;
                            dropped_flag <= drop_reg;
                            last_result <= 1'b0;
                            ov_reg <= 1'b1;
                        end
                        pend_reg <= 1'b1;
                        pend_key_reg <= cur_reg;
                        pend_cost_reg <= cost_reg;
                        i_reg <= i_reg + 1'b1;
                        st_reg <= S_PI;
                    end
                end
                S_FIN:
                begin
                    if (!ov_reg)
                    begin
                        edge_valid <= pend_reg;
                        tree_u <= pend_reg ? pu : '0;
                        tree_v <= pend_reg ? pv : '0;
                        chosen_weight <= pend_reg ? pw : '0;
                        running_cost <= pend_reg ? pend_cost_reg : '0;
                        dropped_flag <= drop_reg;
                        last_result <= 1'b1;
                        ov_reg <= 1'b1;
                        st_reg <= S_INIT;
                    end
                end
                default:
                begin
                    st_reg <= S_INIT;
                end
            endcase
        end
    end

    a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= EMAX) else $error("edge store overfill");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !pop |=> ov_reg && $stable({edge_valid, tree_u, tree_v, chosen_weight,
            running_cost, dropped_flag, last_result})) else $error("result changed while held");
    a_pop_load: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> st_reg == S_LOAD) else $error("queue read outside load");
    a_shift_idx: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == S_SC |-> j_reg != '0) else $error("shift below entry zero");
endmodule

/* rtl/core/kruskal_mst_engine_unit.sv */
// Top level of the spanning tree engine: count register, front end and back end.
// Throughput: one edge transfer per cycle while the back end loads; runs are sequential.
// After the last edge is loaded, the stored edges are sorted by insertion, then scanned
// in order with a parent lookup for each endpoint; an edge that joins two sets is kept.
// A kept edge leaves when the next one is found or the scan ends, then a clearing pass
// over every set entry runs. Reset: async, runs the same pass, count 64, results empty.
`timescale 1ns / 1ps
module kruskal_mst_engine_unit #(
    parameter int MAX_VERTICES = kmst_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = kmst_pkg::DEF_MAX_EDGES
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  logic signed [kmst_pkg::W_WIDTH-1:0] edge_weight,
    input  logic [kmst_pkg::ID_WIDTH-1:0] end_u,
    input  logic [kmst_pkg::ID_WIDTH-1:0] end_v,
    input  logic last_edge,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [kmst_pkg::CNT_WIDTH-1:0] cfg_data,
    output logic empty,
    input  logic pop,
    output logic edge_valid,
    output logic [kmst_pkg::ID_WIDTH-1:0] tree_u,
    output logic [kmst_pkg::ID_WIDTH-1:0] tree_v,
    output logic signed [kmst_pkg::W_WIDTH-1:0] chosen_weight,
    output logic signed [kmst_pkg::COST_WIDTH-1:0] running_cost,
    output logic dropped_flag,
    output logic last_result
);
    import kmst_pkg::*;
    logic [CNT_WIDTH-1:0] vc_reg;
    logic q_valid, q_pop;
    cmd_t q_data;

    // The count register takes a transfer on any cycle; the front end
    // checks each edge against the count in force when it is accepted.
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= VCOUNT_RESET;
        end
        else if (cfg_valid)
        begin
            vc_reg <= cfg_data;
        end
    end

    // Front: classify edges and queue them; back: store, sort, scan, emit.
    kmst_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
        .clk, .rst_n, .push, .full, .edge_weight, .end_u, .end_v, .last_edge,
        .vcount(vc_reg), .q_valid, .q_data, .q_pop);
    kmst_back #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_back (
        .clk, .rst_n, .q_valid, .q_data, .q_pop, .empty, .pop, .edge_valid,
        .tree_u, .tree_v, .chosen_weight, .running_cost, .dropped_flag,
        .last_result);
endmodule
